// ----- design/vgqm_pkg.sv -----
package vgqm_pkg;

    localparam int VOXEL_W = 8;
    localparam int COORD_W = 6;
    localparam int POS_W   = 5;
    localparam int EXT_W   = 6;
    localparam int INDEX_W = 18;
    localparam int FACE_W  = 3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PULL  = 1'b1;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] pad_x;
        logic [COORD_W-1:0] pad_y;
        logic [COORD_W-1:0] pad_z;
        logic [VOXEL_W-1:0] voxel_value;
    } in_word_t;

    typedef struct packed {
        logic               done_res;
        logic [INDEX_W-1:0] quad_index;
        logic [FACE_W-1:0]  face_dir;
        logic [VOXEL_W-1:0] quad_type;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [EXT_W-1:0]   quad_width;
        logic [EXT_W-1:0]   quad_height;
    } out_word_t;

endpackage

// ----- design/vgqm_voxel_ram.sv -----
module vgqm_voxel_ram #(
    parameter int DEPTH = 39304,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr_a,
    output logic [7:0]    rdata_a,
    input  logic [AW-1:0] raddr_b,
    output logic [7:0]    rdata_b
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/voxel_greedy_quad_mesher.sv -----
// A voxel write gives no word back. A pull that needs a new face mask first builds it,
// one cell a cycle through the dual-read voxel memory, then a flush step; each mask cell
// scanned or compared is read in one state and checked in the next, and the clear step
// zeroes one cell a cycle. One item at a time; the result register lets a write be taken
// while a quad waits. Reset (rst_n, asynchronous, active low) restarts meshing only.
module voxel_greedy_quad_mesher #(
    parameter int CHUNK_SIZE = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  vgqm_pkg::in_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output vgqm_pkg::out_word_t rsp
);
    import vgqm_pkg::*;

    localparam int PADDED = CHUNK_SIZE + 2;
    localparam int CW     = $clog2(CHUNK_SIZE + 1);
    localparam int PCW    = $clog2(PADDED);
    localparam int VA_W   = $clog2(PADDED * PADDED * PADDED);
    localparam int MA_W   = $clog2(CHUNK_SIZE * CHUNK_SIZE);
    localparam int OUT_W  = $bits(out_word_t);
    localparam logic [CW-1:0] CS_C   = CW'(CHUNK_SIZE);
    localparam logic [CW-1:0] LAST_C = CW'(CHUNK_SIZE - 1);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BUILD  = 4'd1;
    localparam logic [3:0] S_BFLUSH = 4'd2;
    localparam logic [3:0] S_SCANRD = 4'd3;
    localparam logic [3:0] S_SCANCK = 4'd4;
    localparam logic [3:0] S_WIDRD  = 4'd5;
    localparam logic [3:0] S_WIDCK  = 4'd6;
    localparam logic [3:0] S_HTRD   = 4'd7;
    localparam logic [3:0] S_HTCK   = 4'd8;
    localparam logic [3:0] S_CLR    = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    function automatic logic [VA_W-1:0] vaddr(input logic [PCW-1:0] x,
                                              input logic [PCW-1:0] y,
                                              input logic [PCW-1:0] z);
        vaddr = VA_W'(z) + VA_W'(x) * VA_W'(PADDED) + VA_W'(y) * VA_W'(PADDED * PADDED);
    endfunction

    function automatic logic [MA_W-1:0] maddr(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col);
        maddr = MA_W'(row) * MA_W'(CHUNK_SIZE) + MA_W'(col);
    endfunction

    logic [3:0]         state_reg;
    logic [FACE_W-1:0]  face_reg;
    logic [CW-1:0]      slice_reg;
    logic [CW-1:0]      cu_reg, cv_reg;
    logic [CW-1:0]      bu_reg, bv_reg;
    logic [CW-1:0]      w_reg, h_reg, i_reg, k_reg;
    logic [VOXEL_W-1:0] t_reg;
    logic               mask_ready_reg, finished_reg;
    logic [INDEX_W-1:0] count_reg;
    logic               bld_vld_reg;
    logic [MA_W-1:0]    bld_maddr_reg;
    logic               rsp_valid_reg;
    out_word_t          rsp_reg;

    logic accept;
    logic wr_in_range;
    logic load_rsp;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign load_rsp  = (state_reg == S_EMIT) && (!rsp_valid_reg || !rsp_stall);

    assign wr_in_range = ({1'b0, req.pad_x} < 7'(PADDED)) && ({1'b0, req.pad_y} < 7'(PADDED))
                      && ({1'b0, req.pad_z} < 7'(PADDED));

    // Voxel memory: one write port for loads, two read ports for cell and neighbour.
    logic            vwe;
    logic [VA_W-1:0] vwaddr, vaddr_c, vaddr_n;
    logic [7:0]      vq_c, vq_n;
    logic [1:0]      axis;
    logic [PCW-1:0]  cx, cy, cz, nx, ny, nz;
    logic [PCW-1:0]  pu, pv, ps;

    assign vwe    = accept && (req.kind == KIND_WRITE) && wr_in_range;
    assign vwaddr = vaddr(PCW'(req.pad_x), PCW'(req.pad_y), PCW'(req.pad_z));
    assign axis   = face_reg[2:1];
    assign pu     = PCW'(bu_reg) + PCW'(1);
    assign pv     = PCW'(bv_reg) + PCW'(1);
    assign ps     = PCW'(slice_reg) + PCW'(1);

    always_comb
    begin
        unique case (axis)
            AXIS_X:
            begin
                cx = ps; cy = pu; cz = pv;
            end
            AXIS_Y:
            begin
                cx = pu; cy = ps; cz = pv;
            end
            default:
            begin
                cx = pu; cy = pv; cz = ps;
            end
        endcase
        nx = cx; ny = cy; nz = cz;
        unique case (axis)
            AXIS_X:  nx = face_reg[0] ? cx - PCW'(1) : cx + PCW'(1);
            AXIS_Y:  ny = face_reg[0] ? cy - PCW'(1) : cy + PCW'(1);
            default: nz = face_reg[0] ? cz - PCW'(1) : cz + PCW'(1);
        endcase
    end

    assign vaddr_c = vaddr(cx, cy, cz);
    assign vaddr_n = vaddr(nx, ny, nz);

    vgqm_voxel_ram #(
        .DEPTH (PADDED * PADDED * PADDED),
        .AW    (VA_W)
    ) u_voxel_ram (
        .clk     (clk),
        .we      (vwe),
        .waddr   (vwaddr),
        .wdata   (req.voxel_value),
        .raddr_a (vaddr_c),
        .rdata_a (vq_c),
        .raddr_b (vaddr_n),
        .rdata_b (vq_n)
    );

    // Face mask memory: build writes, clear writes zero, one registered read port.
    logic [7:0]      mask_mem [CHUNK_SIZE * CHUNK_SIZE];
    logic [7:0]      mask_q;
    logic            mwe;
    logic [MA_W-1:0] mwaddr, mraddr;
    logic [7:0]      mwdata;
    logic [CW-1:0]   rd_row, rd_col;

    always_comb
    begin
        mwe    = 1'b0;
        mwaddr = bld_maddr_reg;
        mwdata = 8'd0;
        if (bld_vld_reg)
        begin
            mwe    = 1'b1;
            mwdata = (vq_c != 8'd0 && vq_n == 8'd0) ? vq_c : 8'd0;
        end
        else if (state_reg == S_CLR)
        begin
            mwe    = 1'b1;
            mwaddr = maddr(cv_reg + k_reg, cu_reg + i_reg);
        end
    end

    always_comb
    begin
        rd_row = cv_reg;
        rd_col = cu_reg;
        case (state_reg)
            S_WIDRD: rd_col = cu_reg + w_reg;
            S_HTRD:
            begin
                rd_row = cv_reg + h_reg;
                rd_col = cu_reg + i_reg;
            end
            default: ;
        endcase
    end

    assign mraddr = maddr(rd_row, rd_col);

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mask_mem[mwaddr] <= mwdata;
        end
        mask_q <= mask_mem[mraddr];
    end

    // Quad origin in unpadded chunk coordinates.
    logic [CW-1:0] qx, qy, qz;

    always_comb
    begin
        unique case (axis)
            AXIS_X:
            begin
                qx = slice_reg; qy = cu_reg; qz = cv_reg;
            end
            AXIS_Y:
            begin
                qx = cu_reg; qy = slice_reg; qz = cv_reg;
            end
            default:
            begin
                qx = cu_reg; qy = cv_reg; qz = slice_reg;
            end
        endcase
    end

    // Build pipeline: cell address registered to line up with the voxel read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bld_vld_reg <= 1'b0;
        end
        else
        begin
            bld_vld_reg <= (state_reg == S_BUILD);
        end
    end

    always_ff @(posedge clk)
    begin
        bld_maddr_reg <= maddr(bv_reg, bu_reg);
    end

    // Result register: hold the word until the far side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            if (finished_reg)
            begin
                rsp_reg <= {1'b1, {(OUT_W - 1){1'b0}}};
            end
            else
            begin
                rsp_reg.done_res    <= 1'b0;
                rsp_reg.quad_index  <= count_reg;
                rsp_reg.face_dir    <= face_reg;
                rsp_reg.quad_type   <= t_reg;
                rsp_reg.pos_x       <= POS_W'(qx);
                rsp_reg.pos_y       <= POS_W'(qy);
                rsp_reg.pos_z       <= POS_W'(qz);
                rsp_reg.quad_width  <= EXT_W'(w_reg);
                rsp_reg.quad_height <= EXT_W'(h_reg);
            end
        end
    end

    // Sequencer: build mask, scan for a seed, grow along u then v, clear, emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            face_reg       <= FACE_POS_X;
            slice_reg      <= '0;
            cu_reg         <= '0;
            cv_reg         <= '0;
            bu_reg         <= '0;
            bv_reg         <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            t_reg          <= '0;
            mask_ready_reg <= 1'b0;
            finished_reg   <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.kind == KIND_WRITE)
                        begin
                            face_reg       <= FACE_POS_X;
                            slice_reg      <= '0;
                            cu_reg         <= '0;
                            cv_reg         <= '0;
                            mask_ready_reg <= 1'b0;
                            finished_reg   <= 1'b0;
                            count_reg      <= '0;
                        end
                        else if (finished_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else if (!mask_ready_reg)
                        begin
                            bu_reg    <= '0;
                            bv_reg    <= '0;
                            state_reg <= S_BUILD;
                        end
                        else
                        begin
                            state_reg <= S_SCANRD;
                        end
                    end
                end
                S_BUILD:
                begin
                    if (bu_reg == LAST_C)
                    begin
                        bu_reg <= '0;
                        if (bv_reg == LAST_C)
                        begin
                            state_reg <= S_BFLUSH;
                        end
                        else
                        begin
                            bv_reg <= bv_reg + ONE_C;
                        end
                    end
                    else
                    begin
                        bu_reg <= bu_reg + ONE_C;
                    end
                end
                S_BFLUSH:
                begin
                    mask_ready_reg <= 1'b1;
                    cu_reg         <= '0;
                    cv_reg         <= '0;
                    state_reg      <= S_SCANRD;
                end
                S_SCANRD:
                begin
                    state_reg <= (cv_reg == CS_C) ? S_NEXT : S_SCANCK;
                end
                S_SCANCK:
                begin
                    if (mask_q == 8'd0)
                    begin
                        if (cu_reg == LAST_C)
                        begin
                            cu_reg <= '0;
                            cv_reg <= cv_reg + ONE_C;
                        end
                        else
                        begin
                            cu_reg <= cu_reg + ONE_C;
                        end
                        state_reg <= S_SCANRD;
                    end
                    else
                    begin
                        t_reg     <= mask_q;
                        w_reg     <= ONE_C;
                        state_reg <= S_WIDRD;
                    end
                end
                S_WIDRD:
                begin
                    if (cu_reg + w_reg == CS_C)
                    begin
                        h_reg     <= ONE_C;
                        i_reg     <= '0;
                        state_reg <= S_HTRD;
                    end
                    else
                    begin
                        state_reg <= S_WIDCK;
                    end
                end
                S_WIDCK:
                begin
                    if (mask_q == t_reg)
                    begin
                        w_reg     <= w_reg + ONE_C;
                        state_reg <= S_WIDRD;
                    end
                    else
                    begin
                        h_reg     <= ONE_C;
                        i_reg     <= '0;
                        state_reg <= S_HTRD;
                    end
                end
                S_HTRD:
                begin
                    if (cv_reg + h_reg == CS_C)
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        state_reg <= S_HTCK;
                    end
                end
                S_HTCK:
                begin
                    if (mask_q != t_reg)
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_CLR;
                    end
                    else if (i_reg == w_reg - ONE_C)
                    begin
                        h_reg     <= h_reg + ONE_C;
                        i_reg     <= '0;
                        state_reg <= S_HTRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + ONE_C;
                        state_reg <= S_HTRD;
                    end
                end
                S_CLR:
                begin
                    if (i_reg == w_reg - ONE_C)
                    begin
                        i_reg <= '0;
                        if (k_reg == h_reg - ONE_C)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            k_reg <= k_reg + ONE_C;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + ONE_C;
                    end
                end
                S_NEXT:
                begin
                    // slice exhausted: advance slice, then face
                    mask_ready_reg <= 1'b0;
                    bu_reg         <= '0;
                    bv_reg         <= '0;
                    if (slice_reg == LAST_C)
                    begin
                        slice_reg <= '0;
                        if (face_reg == FACE_NEG_Z)
                        begin
                            face_reg     <= FACE_POS_X;
                            finished_reg <= 1'b1;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            face_reg  <= face_reg + FACE_W'(1);
                            state_reg <= S_BUILD;
                        end
                    end
                    else
                    begin
                        slice_reg <= slice_reg + ONE_C;
                        state_reg <= S_BUILD;
                    end
                end
                S_EMIT:
                begin
                    if (load_rsp)
                    begin
                        if (!finished_reg)
                        begin
                            count_reg <= count_reg + INDEX_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/voxel_greedy_quad_mesher_tb.sv -----
`timescale 1ns / 100ps

module voxel_greedy_quad_mesher_tb;
    import vgqm_pkg::*;

    localparam int CS        = 32;
    localparam int PAD       = CS + 2;
    localparam int NUM_FACES = FACE_NEG_Z + 1;
    localparam int IN_W      = $bits(in_word_t);
    localparam int LIMIT     = 1_000_000_000;
    localparam int HOLD_LEN  = 3000;
    localparam int DRAIN     = 64;

    // Scoreboard: keeps its own copy of the voxel cube and the scan state,
    // predicts the quad (or done word) for each accepted pull and checks
    // returned words against the oldest prediction.
    class mesh_scoreboard;
        bit [7:0]        vox[PAD*PAD*PAD];
        bit [7:0]        face_mask[CS*CS];
        int              face, slice, su, sv;
        bit              ready, fin;
        bit [17:0]       qcnt;
        out_word_t       quads_due[$];
        int              mismatches;

        function void restart();
            face = 0; slice = 0; su = 0; sv = 0;
            ready = 0; fin = 0; qcnt = 0;
        endfunction

        function int cube_at(int x, int y, int z);
            return z + x*PAD + y*PAD*PAD;
        endfunction

        // Build the visible-face mask for the current face and slice.
        function void build_mask();
            int ax, u, v, c[3], n[3];
            bit [7:0] t;
            ax = face >> 1;
            for (v = 0; v < CS; v++)
                for (u = 0; u < CS; u++)
                begin
                    if (ax == AXIS_X) begin c[0] = slice; c[1] = u; c[2] = v; end
                    else if (ax == AXIS_Y) begin c[0] = u; c[1] = slice; c[2] = v; end
                    else begin c[0] = u; c[1] = v; c[2] = slice; end
                    c[0]++; c[1]++; c[2]++;
                    n = c;
                    if (face & 1) n[ax]--; else n[ax]++;
                    t = vox[cube_at(c[0], c[1], c[2])];
                    if (t != 0 && vox[cube_at(n[0], n[1], n[2])] != 0)
                        t = 0;
                    face_mask[v*CS+u] = t;
                end
            su = 0; sv = 0; ready = 1;
        endfunction

        function out_word_t next_quad();
            out_word_t r;
            int u, v, w, h, i, k, u0;
            bit [7:0] t;
            bit grow;
            r = '0;
            while (1)
            begin
                if (fin)
                begin
                    r.done_res = 1'b1;
                    return r;
                end
                if (!ready)
                    build_mask();
                for (v = sv; v < CS; v++)
                begin
                    u0 = (v == sv) ? su : 0;
                    for (u = u0; u < CS; u++)
                    begin
                        t = face_mask[v*CS+u];
                        if (t == 0)
                            continue;
                        w = 1; h = 1; grow = 1;
                        while (u + w < CS && face_mask[v*CS+u+w] == t)
                            w++;
                        while (grow && v + h < CS)
                        begin
                            for (i = 0; i < w; i++)
                                if (face_mask[(v+h)*CS+u+i] != t)
                                    grow = 0;
                            if (grow)
                                h++;
                        end
                        for (k = 0; k < h; k++)
                            for (i = 0; i < w; i++)
                                face_mask[(v+k)*CS+u+i] = 0;
                        r.quad_index = qcnt;
                        r.face_dir   = face[FACE_W-1:0];
                        r.quad_type  = t;
                        if ((face >> 1) == AXIS_X)
                        begin
                            r.pos_x = slice[4:0]; r.pos_y = u[4:0]; r.pos_z = v[4:0];
                        end
                        else if ((face >> 1) == AXIS_Y)
                        begin
                            r.pos_x = u[4:0]; r.pos_y = slice[4:0]; r.pos_z = v[4:0];
                        end
                        else
                        begin
                            r.pos_x = u[4:0]; r.pos_y = v[4:0]; r.pos_z = slice[4:0];
                        end
                        r.quad_width  = w[EXT_W-1:0];
                        r.quad_height = h[EXT_W-1:0];
                        qcnt++;
                        su = u; sv = v;
                        return r;
                    end
                end
                // Slice exhausted: advance to the next slice, then the next face.
                ready = 0;
                slice++;
                if (slice >= CS)
                begin
                    slice = 0;
                    face++;
                    if (face >= NUM_FACES)
                    begin
                        face = 0;
                        fin = 1;
                    end
                end
            end
        endfunction

        function void note_input(in_word_t w);
            if (w.kind == KIND_WRITE)
            begin
                if (w.pad_x < PAD && w.pad_y < PAD && w.pad_z < PAD)
                    vox[cube_at(w.pad_x, w.pad_y, w.pad_z)] = w.voxel_value;
                restart();
            end
            else
                quads_due.insert(quads_due.size(), next_quad());
        endfunction

        function void check(out_word_t got);
            out_word_t exp_q;
            if (quads_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", got);
                return;
            end
            exp_q = quads_due.pop_front();
            if (got.done_res !== exp_q.done_res || got.quad_index !== exp_q.quad_index ||
                got.face_dir !== exp_q.face_dir || got.quad_type !== exp_q.quad_type ||
                got.pos_x !== exp_q.pos_x || got.pos_y !== exp_q.pos_y ||
                got.pos_z !== exp_q.pos_z || got.quad_width !== exp_q.quad_width ||
                got.quad_height !== exp_q.quad_height)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp_q, got);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_word_t  req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_word_t rsp;

    mesh_scoreboard sb;
    int  send_idle_pct = 0;
    int  rsp_stall_pct = 0;
    bit  pressure_req = 0;
    int  cycles = 0;
    int  items = 0;

    voxel_greedy_quad_mesher #(.CHUNK_SIZE(CS)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Hard limit on run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("** voxel_greedy_quad_mesher: FAILED **");
            $finish;
        end
    end

    // Receiver: drive stall at the falling edge. Once asked, hold off for a long
    // stretch so that a quad waits and the block backs up its input.
    always @(negedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_used = 0;
        if (pressure_req && !hold_used)
        begin
            hold_used = 1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end

    // Sample returned words at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check(rsp);
    end

    // Offer one word; called at a falling edge, returns at a falling edge.
    task automatic send_word(in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_input(w);
        items++;
        @(negedge clk);
    endtask

    task automatic write_voxel(int x, int y, int z, int val);
        in_word_t w;
        w = '0;
        w.kind = KIND_WRITE;
        w.pad_x = x[COORD_W-1:0];
        w.pad_y = y[COORD_W-1:0];
        w.pad_z = z[COORD_W-1:0];
        w.voxel_value = val[VOXEL_W-1:0];
        send_word(w);
    endtask

    // Pull with junk in the unused fields: the block must ignore them.
    task automatic pull_quad();
        in_word_t w;
        w = IN_W'($urandom);
        w.kind = KIND_PULL;
        send_word(w);
    endtask

    // Well-formed traffic: a small rectangle of one type near the low-x end,
    // then a handful of pulls. Noise: random writes anywhere (out of range too)
    // and bare pulls.
    task automatic random_burst();
        int pick, x, y0, z0, bw, bh, val, i, j, n;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            x  = $urandom_range(1, 3);
            y0 = $urandom_range(2, 31);
            z0 = $urandom_range(2, 31);
            bw = $urandom_range(1, 3);
            bh = $urandom_range(1, 3);
            case ($urandom_range(0, 9))
                0:       val = 0;
                1, 2:    val = $urandom_range(0, 255);
                default: val = $urandom_range(1, 3);
            endcase
            for (i = 0; i < bw; i++)
                for (j = 0; j < bh; j++)
                    write_voxel(x, y0 + i, z0 + j, val);
            n = $urandom_range(1, 6);
        end
        else if (pick < 85)
        begin
            write_voxel($urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 255));
            n = $urandom_range(0, 2);
        end
        else
            n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            pull_quad();
    endtask

    initial
    begin
        int x, y, z, ph, target;
        sb = new();
        sb.restart();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every padded cell so that no mesh reads an unwritten voxel.
        for (y = 0; y < PAD; y++)
            for (x = 0; x < PAD; x++)
                for (z = 0; z < PAD; z++)
                    write_voxel(x, y, z, 0);

        // Directed: corner voxels, a merged run, out-of-range writes,
        // then mesh right through to done and pull once more past it.
        write_voxel(1, 1, 1, 255);
        pull_quad();
        pull_quad();
        write_voxel(PAD - 2, PAD - 2, PAD - 2, 8'h80);
        write_voxel(1, 2, 5, 7);
        write_voxel(1, 3, 5, 7);
        write_voxel(1, 4, 5, 7);
        write_voxel(1, 2, 6, 7);
        write_voxel(1, 3, 6, 7);
        write_voxel(1, 4, 6, 7);
        write_voxel(PAD, 0, 0, 9);
        write_voxel(63, 63, 63, 255);
        repeat (20) pull_quad();
        write_voxel(0, 0, 0, 0);
        pull_quad();
        pull_quad();

        // Random part in four idling phases; the long receiver hold-off
        // lands at the start of the first.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  pressure_req = 1; end
                1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
                default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
            endcase
            target = items + 290;
            while (items < target)
                random_burst();
        end
        req_valid <= 1'b0;

        // Drain: wait for every outstanding word, then a little longer.
        while (sb.quads_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (sb.mismatches == 0 && sb.quads_due.size() == 0)
            $display("** voxel_greedy_quad_mesher: PASSED **");
        else
            $display("** voxel_greedy_quad_mesher: FAILED **");
        $finish;
    end

endmodule
